/* hw/rtl/tpi_pkg.sv */
// tpi_pkg: shared types, codes and constants of the tabulated potential interpolator
// no dependencies
`timescale 1ns / 1ps
package tpi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DSQ_W = 32;
   localparam int RAD_W = 32;
   localparam int ENG_W = 32;
   localparam int OUT_W = 48;
   localparam int IDX_W = 10;
   localparam int LEN_W = 11;
   localparam int OVL_W = 47;
   localparam int CSR_W = 47;
   localparam int ROOT_W = (DSQ_W + FRAC_BITS) / 2;
   localparam int TABLE_DEPTH_DEFAULT = 1024;

   localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(2);
   localparam logic [RAD_W-1:0] ORIGIN_RESET = '0;
   localparam logic [RAD_W-1:0] SPACING_RESET = RAD_W'(64'd1 << FRAC_BITS);
   localparam logic [OVL_W-1:0] OVERLAP_RESET = OVL_W'(64'd1000000 << FRAC_BITS);

   typedef enum logic [1:0] {
      CSR_LENGTH  = 2'd0,
      CSR_ORIGIN  = 2'd1,
      CSR_SPACING = 2'd2,
      CSR_OVERLAP = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_INTERP = 2'd0,
      ST_BELOW  = 2'd1,
      ST_ABOVE  = 2'd2,
      ST_LOAD   = 2'd3
   } status_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         idx;
      logic [RAD_W-1:0]         radius;
      logic signed [ENG_W-1:0]  energy;
   } req_type;

   typedef struct packed {
      req_type                  req;
      logic [ROOT_W-1:0]        root;
   } q_type;

   typedef struct packed {
      logic [RAD_W-1:0]         r0;
      logic [RAD_W-1:0]         rlim;
      logic [RAD_W-1:0]         r1;
      logic [RAD_W-1:0]         r2;
      logic signed [ENG_W-1:0]  v1;
      logic signed [ENG_W-1:0]  v2;
   } rd_type;

   typedef struct packed {
      status_type               status;
      logic                     neg;
      logic                     ddz;
      logic                     sat;
      logic signed [ENG_W-1:0]  v1;
   } fin_type;

endpackage

/* hw/rtl/tabulated_potential_interpolator_top.sv */
// tabulated_potential_interpolator_top: request pipeline, config registers and final blend
// depends on tpi_pkg, tpi_sqrt, tpi_div, tpi_table
`timescale 1ns / 1ps
// Takes one request per clock while no response waits and returns one response per
// request, in order. Most of the pipeline lies in the bit-per-stage units: a 24-stage
// square root of the squared distance, a 24-stage divider for the grid interval and a
// 49-stage divider for the interpolation quotient. Loads travel the same pipeline and
// write the table at the read stage, so loads and queries take effect in request order.
// The whole pipeline holds while a response waits; req_ready is low only then. Table
// entries that were never loaded read back undefined.
module tabulated_potential_interpolator_top #(
   parameter int TABLE_DEPTH = tpi_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [tpi_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [tpi_pkg::RAD_W-1:0]         req_entry_radius,
   input  logic signed [tpi_pkg::ENG_W-1:0]  req_entry_energy,
   input  logic [tpi_pkg::DSQ_W-1:0]         req_distance_squared,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [tpi_pkg::OUT_W-1:0]  rsp_energy,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [tpi_pkg::CSR_W-1:0]         csr_write_data
);
   import tpi_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int PROD_W = 2 * RAD_W;
   localparam int QW = 49;
   localparam int HI_W = PROD_W - QW;
   localparam int SUM_W = OUT_W + 3;

   logic advance;

   // config registers
   logic [LEN_W-1:0] len_ff;
   logic [RAD_W-1:0] origin_ff, spacing_ff;
   logic [OVL_W-1:0] overlap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= LENGTH_RESET;
         origin_ff  <= ORIGIN_RESET;
         spacing_ff <= SPACING_RESET;
         overlap_ff <= OVERLAP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_LENGTH:  len_ff     <= csr_write_data[LEN_W-1:0];
            CSR_ORIGIN:  origin_ff  <= csr_write_data[RAD_W-1:0];
            CSR_SPACING: spacing_ff <= csr_write_data[RAD_W-1:0];
            CSR_OVERLAP: overlap_ff <= csr_write_data[OVL_W-1:0];
            default: ;
         endcase
      end
   end

   logic [31:0]   len32, n32, nm2_32;
   logic [AW-1:0] last_idx;

   always_comb begin
      len32 = 32'(len_ff);
      if (len32 < 32'd2) begin
         n32 = 32'd2;
      end else if (len32 > 32'(TABLE_DEPTH)) begin
         n32 = 32'(TABLE_DEPTH);
      end else begin
         n32 = len32;
      end
      nm2_32   = n32 - 32'd2;
      last_idx = AW'(n32 - 32'd1);
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // input stage
   logic             a_valid_ff;
   req_type          a_req_ff;
   logic [DSQ_W-1:0] a_dsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_req_ff.op     <= op_type'(req_operation);
         a_req_ff.idx    <= req_entry_index;
         a_req_ff.radius <= req_entry_radius;
         a_req_ff.energy <= req_entry_energy;
         a_dsq_ff        <= req_distance_squared;
      end
   end

   // square root
   logic              s_valid;
   logic [ROOT_W-1:0] s_root;
   req_type           s_req;

   tpi_sqrt #(
      .ROOT_W    (ROOT_W),
      .side_type (req_type)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (a_valid_ff),
      .in_value  ({a_dsq_ff, {FRAC_BITS{1'b0}}}),
      .in_side   (a_req_ff),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_req)
   );

   // offset from grid origin
   logic              b_valid_ff;
   q_type             b_q_ff;
   logic [ROOT_W-1:0] b_num_ff;
   logic [ROOT_W-1:0] b_num_in;

   always_comb begin
      if (32'(s_root) < origin_ff) begin
         b_num_in = '0;
      end else begin
         b_num_in = ROOT_W'(32'(s_root) - origin_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_q_ff.req  <= s_req;
         b_q_ff.root <= s_root;
         b_num_ff    <= b_num_in;
      end
   end

   // interval divide
   logic              g_valid;
   logic [ROOT_W-1:0] g_quot;
   q_type             g_q;

   tpi_div #(
      .NUM_W     (ROOT_W),
      .DEN_W     (RAD_W),
      .side_type (q_type)
   ) u_grid_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (b_valid_ff),
      .in_rem    ('0),
      .in_num    (b_num_ff),
      .in_den    (spacing_ff),
      .in_side   (b_q_ff),
      .out_valid (g_valid),
      .out_quot  (g_quot),
      .out_side  (g_q)
   );

   // interval clamp
   logic          c_valid_ff;
   q_type         c_q_ff;
   logic [AW-1:0] c_i_ff;
   logic [AW-1:0] c_i_in;

   always_comb begin
      if (32'(g_q.root) < origin_ff) begin
         c_i_in = '0;
      end else if (32'(g_quot) > nm2_32) begin
         c_i_in = AW'(nm2_32);
      end else begin
         c_i_in = AW'(32'(g_quot));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= g_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_q_ff <= g_q;
         c_i_ff <= c_i_in;
      end
   end

   // table access
   rd_type d_rd;

   tpi_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .advance   (advance),
      .in_valid  (c_valid_ff),
      .in_load   (c_q_ff.req.op == OP_LOAD),
      .in_idx    (c_q_ff.req.idx),
      .in_radius (c_q_ff.req.radius),
      .in_energy (c_q_ff.req.energy),
      .in_i      (c_i_ff),
      .in_last   (last_idx),
      .out_rd    (d_rd)
   );

   logic              d_valid_ff;
   op_type            d_op_ff;
   logic [ROOT_W-1:0] d_root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_op_ff   <= c_q_ff.req.op;
         d_root_ff <= c_q_ff.root;
      end
   end

   // differences, signs and range class
   logic                     e_valid_ff;
   status_type               e_status_ff, e_status_in;
   logic [RAD_W-1:0]         e_mdr_ff, e_mdv_ff, e_mdd_ff;
   logic [RAD_W-1:0]         e_mdr_in, e_mdv_in, e_mdd_in;
   logic                     e_neg_ff, e_neg_in, e_ddz_ff, e_ddz_in;
   logic signed [ENG_W-1:0]  e_v1_ff;
   logic [RAD_W-1:0]         d_root32;
   logic signed [RAD_W+1:0]  dr, dv, dd, adr, adv, add;

   always_comb begin
      d_root32 = RAD_W'(d_root_ff);
      dr       = $signed({2'b00, d_root32}) - $signed({2'b00, d_rd.r1});
      dd       = $signed({2'b00, d_rd.r2}) - $signed({2'b00, d_rd.r1});
      dv       = (RAD_W+2)'(d_rd.v2) - (RAD_W+2)'(d_rd.v1);
      adr      = dr[RAD_W+1] ? -dr : dr;
      adv      = dv[RAD_W+1] ? -dv : dv;
      add      = dd[RAD_W+1] ? -dd : dd;
      e_mdr_in = adr[RAD_W-1:0];
      e_mdv_in = adv[RAD_W-1:0];
      e_mdd_in = add[RAD_W-1:0];
      e_neg_in = dr[RAD_W+1] ^ dv[RAD_W+1] ^ dd[RAD_W+1];
      e_ddz_in = (dd == '0);
      if (d_op_ff == OP_LOAD) begin
         e_status_in = ST_LOAD;
      end else if (d_root32 < d_rd.r0) begin
         e_status_in = ST_BELOW;
      end else if (d_root32 > d_rd.rlim) begin
         e_status_in = ST_ABOVE;
      end else begin
         e_status_in = ST_INTERP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_status_ff <= e_status_in;
         e_mdr_ff    <= e_mdr_in;
         e_mdv_ff    <= e_mdv_in;
         e_mdd_ff    <= e_mdd_in;
         e_neg_ff    <= e_neg_in;
         e_ddz_ff    <= e_ddz_in;
         e_v1_ff     <= d_rd.v1;
      end
   end

   // product
   logic                    f_valid_ff;
   logic [PROD_W-1:0]       f_prod_ff;
   logic [RAD_W-1:0]        f_mdd_ff;
   fin_type                 f_side_ff;
   fin_type                 f_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_prod_ff        <= PROD_W'(e_mdr_ff) * PROD_W'(e_mdv_ff);
         f_mdd_ff         <= e_mdd_ff;
         f_side_ff.status <= e_status_ff;
         f_side_ff.neg    <= e_neg_ff;
         f_side_ff.ddz    <= e_ddz_ff;
         f_side_ff.sat    <= 1'b0;
         f_side_ff.v1     <= e_v1_ff;
      end
   end

   always_comb begin
      f_side     = f_side_ff;
      f_side.sat = (RAD_W'(f_prod_ff[PROD_W-1 -: HI_W]) >= f_mdd_ff);
   end

   // interpolation divide
   logic          h_valid;
   logic [QW-1:0] h_quot;
   fin_type       h_side;

   tpi_div #(
      .NUM_W     (QW),
      .DEN_W     (RAD_W),
      .side_type (fin_type)
   ) u_interp_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f_valid_ff),
      .in_rem    (RAD_W'(f_prod_ff[PROD_W-1 -: HI_W])),
      .in_num    (f_prod_ff[QW-1:0]),
      .in_den    (f_mdd_ff),
      .in_side   (f_side),
      .out_valid (h_valid),
      .out_quot  (h_quot),
      .out_side  (h_side)
   );

   // blend, saturate and select
   localparam logic [QW-1:0] Q_CAP = QW'(64'd1 << OUT_W);
   localparam logic signed [SUM_W-1:0] E_MAX = SUM_W'((64'd1 << (OUT_W - 1)) - 64'd1);
   localparam logic signed [SUM_W-1:0] E_MIN = -SUM_W'(64'd1 << (OUT_W - 1));

   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_energy_ff, rsp_energy_in;
   status_type               rsp_status_ff;
   logic [QW-1:0]            qc;
   logic signed [SUM_W-1:0]  v1x, qx, sum;
   logic signed [OUT_W-1:0]  interp_e;

   always_comb begin
      qc  = (h_side.sat || (h_quot > Q_CAP)) ? Q_CAP : h_quot;
      v1x = SUM_W'(h_side.v1);
      qx  = $signed(SUM_W'(qc));
      sum = h_side.neg ? (v1x - qx) : (v1x + qx);
      if (h_side.ddz) begin
         interp_e = OUT_W'(h_side.v1);
      end else if (sum > E_MAX) begin
         interp_e = E_MAX[OUT_W-1:0];
      end else if (sum < E_MIN) begin
         interp_e = E_MIN[OUT_W-1:0];
      end else begin
         interp_e = sum[OUT_W-1:0];
      end
      case (h_side.status)
         ST_INTERP: rsp_energy_in = interp_e;
         ST_BELOW:  rsp_energy_in = $signed({1'b0, overlap_ff});
         ST_ABOVE:  rsp_energy_in = '0;
         ST_LOAD:   rsp_energy_in = '0;
         default:   rsp_energy_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= h_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_energy_ff <= rsp_energy_in;
         rsp_status_ff <= h_side.status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_energy = rsp_energy_ff;
   assign rsp_status = rsp_status_ff;

   // checks
   a_load_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_LOAD) |-> (rsp_energy == '0))
      else $error("load response carries nonzero energy");

   a_above_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ABOVE) |-> (rsp_energy == '0))
      else $error("above-range response carries nonzero energy");

   a_below_overlap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BELOW) |-> (rsp_energy == $signed({1'b0, overlap_ff})))
      else $error("below-range response is not the overlap energy");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(e_valid_ff) && $stable(c_valid_ff))
      else $error("pipeline moved during a stall");

endmodule

/* hw/rtl/tpi_sqrt.sv */
// tpi_sqrt: pipelined integer square root, one result bit per stage
// generic; sideband type given by the instantiating module
`timescale 1ns / 1ps
module tpi_sqrt #(
   parameter int ROOT_W = 24,
   parameter type side_type = logic
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] in_value,
   input  side_type            in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output side_type            out_side
);
   localparam int VAL_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic              valid_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [VAL_W-1:0]  val_ff   [ROOT_W];
   side_type          side_ff  [ROOT_W];

   logic              src_valid [ROOT_W];
   logic [REM_W-1:0]  src_rem   [ROOT_W];
   logic [ROOT_W-1:0] src_root  [ROOT_W];
   logic [VAL_W-1:0]  src_val   [ROOT_W];
   side_type          src_side  [ROOT_W];

   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [VAL_W-1:0]  val_in  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign src_valid[k] = in_valid;
         assign src_rem[k]   = '0;
         assign src_root[k]  = '0;
         assign src_val[k]   = in_value;
         assign src_side[k]  = in_side;
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign src_rem[k]   = rem_ff[k-1];
         assign src_root[k]  = root_ff[k-1];
         assign src_val[k]   = val_ff[k-1];
         assign src_side[k]  = side_ff[k-1];
      end

      always_comb begin
         rem_t      = {src_rem[k][REM_W-3:0], src_val[k][VAL_W-1 -: 2]};
         trial      = {1'b0, src_root[k], 2'b01};
         ge         = (rem_t >= trial);
         rem_in[k]  = ge ? (rem_t - trial) : rem_t;
         root_in[k] = {src_root[k][ROOT_W-2:0], ge};
         val_in[k]  = {src_val[k][VAL_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            val_ff[k]  <= val_in[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

/* hw/rtl/tpi_div.sv */
// tpi_div: pipelined restoring divider, one quotient bit per stage
// generic; caller keeps the starting remainder below the divisor
`timescale 1ns / 1ps
module tpi_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 32,
   parameter type side_type = logic
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_rem,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output side_type         out_side
);
   logic             valid_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [NUM_W-1:0] nq_ff    [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   side_type         side_ff  [NUM_W];

   logic             src_valid [NUM_W];
   logic [DEN_W-1:0] src_rem   [NUM_W];
   logic [NUM_W-1:0] src_nq    [NUM_W];
   logic [DEN_W-1:0] src_den   [NUM_W];
   side_type         src_side  [NUM_W];

   logic [DEN_W-1:0] rem_in [NUM_W];
   logic [NUM_W-1:0] nq_in  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0] rem_t;
      logic [DEN_W:0] den_x;
      logic [DEN_W:0] diff;
      logic           ge;

      if (k == 0) begin : g_first
         assign src_valid[k] = in_valid;
         assign src_rem[k]   = in_rem;
         assign src_nq[k]    = in_num;
         assign src_den[k]   = in_den;
         assign src_side[k]  = in_side;
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign src_rem[k]   = rem_ff[k-1];
         assign src_nq[k]    = nq_ff[k-1];
         assign src_den[k]   = den_ff[k-1];
         assign src_side[k]  = side_ff[k-1];
      end

      always_comb begin
         rem_t     = {src_rem[k], src_nq[k][NUM_W-1]};
         den_x     = {1'b0, src_den[k]};
         ge        = (rem_t >= den_x);
         diff      = rem_t - den_x;
         rem_in[k] = ge ? diff[DEN_W-1:0] : rem_t[DEN_W-1:0];
         nq_in[k]  = {src_nq[k][NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            den_ff[k]  <= src_den[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

/* hw/rtl/tpi_table.sv */
// tpi_table: radius and energy storage in even and odd banks plus a limit copy
// depends on tpi_pkg
`timescale 1ns / 1ps
module tpi_table #(
   parameter int TABLE_DEPTH = tpi_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic                             in_load,
   input  logic [tpi_pkg::IDX_W-1:0]        in_idx,
   input  logic [tpi_pkg::RAD_W-1:0]        in_radius,
   input  logic signed [tpi_pkg::ENG_W-1:0] in_energy,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   in_i,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   in_last,
   output tpi_pkg::rd_type                  out_rd
);
   import tpi_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int BD = (TABLE_DEPTH + 1) / 2;
   localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

   logic [RAD_W-1:0] rad0_mem [BD];
   logic [ENG_W-1:0] eng0_mem [BD];
   logic [RAD_W-1:0] rad1_mem [BD];
   logic [ENG_W-1:0] eng1_mem [BD];
   logic [RAD_W-1:0] lim_mem  [TABLE_DEPTH];

   logic [RAD_W-1:0] r0_ff;
   logic [RAD_W-1:0] rad0_ff, rad1_ff, lim_ff;
   logic [ENG_W-1:0] eng0_ff, eng1_ff;
   logic             odd_ff;

   logic [31:0]      idx32, i32, ip32;
   logic             idx_ok, wr, rd;
   logic [BAW-1:0]   wbank_addr, rd0_addr, rd1_addr;

   always_comb begin
      idx32      = 32'(in_idx);
      i32        = 32'(in_i);
      ip32       = i32 + 32'd1;
      idx_ok     = (idx32 < 32'(TABLE_DEPTH));
      wr         = advance && in_valid && in_load && idx_ok;
      rd         = advance && in_valid && !in_load;
      wbank_addr = BAW'(idx32 >> 1);
      rd0_addr   = BAW'(ip32 >> 1);
      rd1_addr   = BAW'(i32 >> 1);
   end

   // table writes
   always_ff @(posedge clock) begin
      if (wr) begin
         lim_mem[AW'(idx32)] <= in_radius;
         if (idx32 == 32'd0) begin
            r0_ff <= in_radius;
         end
         if (idx32[0]) begin
            rad1_mem[wbank_addr] <= in_radius;
            eng1_mem[wbank_addr] <= in_energy;
         end else begin
            rad0_mem[wbank_addr] <= in_radius;
            eng0_mem[wbank_addr] <= in_energy;
         end
      end
   end

   // query reads
   always_ff @(posedge clock) begin
      if (rd) begin
         rad0_ff <= rad0_mem[rd0_addr];
         eng0_ff <= eng0_mem[rd0_addr];
         rad1_ff <= rad1_mem[rd1_addr];
         eng1_ff <= eng1_mem[rd1_addr];
         lim_ff  <= lim_mem[in_last];
         odd_ff  <= in_i[0];
      end
   end

   always_comb begin
      out_rd.r0   = r0_ff;
      out_rd.rlim = lim_ff;
      out_rd.r1   = odd_ff ? rad1_ff : rad0_ff;
      out_rd.r2   = odd_ff ? rad0_ff : rad1_ff;
      out_rd.v1   = odd_ff ? $signed(eng1_ff) : $signed(eng0_ff);
      out_rd.v2   = odd_ff ? $signed(eng0_ff) : $signed(eng1_ff);
   end

endmodule

/* dv/tpi_checker.sv */
// tpi_checker: predicts and checks every response of the tabulated potential interpolator
// depends on tpi_pkg; watches request, response and csr ports beside the block
`timescale 1ns / 1ps
module tpi_checker #(
   parameter int TABLE_DEPTH = tpi_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_operation,
   input  logic [tpi_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [tpi_pkg::RAD_W-1:0]         req_entry_radius,
   input  logic signed [tpi_pkg::ENG_W-1:0]  req_entry_energy,
   input  logic [tpi_pkg::DSQ_W-1:0]         req_distance_squared,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [tpi_pkg::OUT_W-1:0]  rsp_energy,
   input  logic [1:0]                        rsp_status,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [tpi_pkg::CSR_W-1:0]         csr_write_data,
   output int                                mismatches,
   output int                                outstanding
);
   import tpi_pkg::*;

   typedef struct {
      logic signed [OUT_W-1:0] energy;
      status_type              status;
   } energy_result_type;

   localparam longint E_MAX = 64'sd140737488355327;
   localparam longint E_MIN = -64'sd140737488355328;

   logic [LEN_W-1:0]  length_q;
   logic [RAD_W-1:0]  origin_q;
   logic [RAD_W-1:0]  spacing_q;
   logic [OVL_W-1:0]  overlap_q;
   logic [RAD_W-1:0]  radius_tab [TABLE_DEPTH];
   logic [ENG_W-1:0]  energy_tab [TABLE_DEPTH];
   energy_result_type expected_energies [$];

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t: %s: got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic bit [63:0] root_of(input logic [DSQ_W-1:0] dsq);
      bit [63:0] v;
      bit [63:0] res;
      bit [63:0] b;
      v = {16'b0, dsq, 16'b0};
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint blend(input int unsigned i, input bit [63:0] r);
      longint r1;
      longint r2;
      longint v1;
      longint v2;
      longint dr;
      longint dv;
      longint dd;
      longint sum;
      bit neg;
      bit [63:0] mdr;
      bit [63:0] mdv;
      bit [63:0] mdd;
      bit [63:0] q;
      r1 = longint'({32'b0, radius_tab[i]});
      r2 = longint'({32'b0, radius_tab[i+1]});
      v1 = longint'(signed'(energy_tab[i]));
      v2 = longint'(signed'(energy_tab[i+1]));
      dr = longint'(r) - r1;
      dv = v2 - v1;
      dd = r2 - r1;
      neg = 0;
      if (dd == 0) return v1;
      if (dr < 0) begin mdr = -dr; neg = !neg; end else mdr = dr;
      if (dv < 0) begin mdv = -dv; neg = !neg; end else mdv = dv;
      if (dd < 0) begin mdd = -dd; neg = !neg; end else mdd = dd;
      q = (mdr * mdv) / mdd;
      if (q > (64'd1 << 48)) q = 64'd1 << 48;
      sum = neg ? v1 - longint'(q) : v1 + longint'(q);
      if (sum > E_MAX) sum = E_MAX;
      if (sum < E_MIN) sum = E_MIN;
      return sum;
   endfunction

   function automatic energy_result_type lookup_energy(input logic [DSQ_W-1:0] dsq);
      energy_result_type res;
      int unsigned n;
      bit [63:0] r;
      bit [63:0] i;
      n = length_q;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      r = root_of(dsq);
      if (r < radius_tab[0]) begin
         res.energy = OUT_W'({1'b0, overlap_q});
         res.status = ST_BELOW;
      end else if (r > radius_tab[n-1]) begin
         res.energy = '0;
         res.status = ST_ABOVE;
      end else begin
         if (r < origin_q) i = 0;
         else if (spacing_q == 0) i = n - 2;
         else i = (r - origin_q) / spacing_q;
         if (i > n - 2) i = n - 2;
         res.energy = OUT_W'(blend(int'(i), r));
         res.status = ST_INTERP;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      energy_result_type res;
      energy_result_type want;
      if (reset) begin
         length_q = LENGTH_RESET;
         origin_q = ORIGIN_RESET;
         spacing_q = SPACING_RESET;
         overlap_q = OVERLAP_RESET;
         mismatches = 0;
         expected_energies.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_LENGTH:  length_q = csr_write_data[LEN_W-1:0];
               CSR_ORIGIN:  origin_q = csr_write_data[RAD_W-1:0];
               CSR_SPACING: spacing_q = csr_write_data[RAD_W-1:0];
               CSR_OVERLAP: overlap_q = csr_write_data[OVL_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_energies.size() == 0) begin
               report("response with no request outstanding", rsp_energy, 0);
            end else begin
               want = expected_energies.pop_front();
               if (rsp_energy !== want.energy)
                  report("energy mismatch", rsp_energy, want.energy);
               if (rsp_status !== want.status)
                  report("status mismatch", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready) begin
            if (op_type'(req_operation) == OP_LOAD) begin
               if (req_entry_index < TABLE_DEPTH) begin
                  radius_tab[req_entry_index] = req_entry_radius;
                  energy_tab[req_entry_index] = req_entry_energy;
               end
               res.energy = '0;
               res.status = ST_LOAD;
            end else begin
               res = lookup_energy(req_distance_squared);
            end
            expected_energies.push_back(res);
         end
      end
      outstanding = expected_energies.size();
   end

endmodule

/* dv/tb.sv */
// tb: stimulus and verdict for the tabulated potential interpolator
// depends on tpi_pkg, tabulated_potential_interpolator_top and tpi_checker
`timescale 1ns / 1ps
module tb;
   import tpi_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEFAULT;
   localparam int IDLE_LIMIT = 20000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_operation = 1'b0;
   logic [IDX_W-1:0]          req_entry_index = '0;
   logic [RAD_W-1:0]          req_entry_radius = '0;
   logic signed [ENG_W-1:0]   req_entry_energy = '0;
   logic [DSQ_W-1:0]          req_distance_squared = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]   rsp_energy;
   logic [1:0]                rsp_status;
   logic                      csr_write_enable = 1'b0;
   logic [1:0]                csr_index = '0;
   logic [CSR_W-1:0]          csr_write_data = '0;
   int                        mismatches;
   int                        outstanding;

   logic                      hold_go = 1'b0;
   logic                      hold_done = 1'b0;
   int                        hold_cnt = 0;
   int                        rx_cycle = 0;
   int                        idle_cycles = 0;
   int                        burst_left = 0;
   int unsigned               eff_len = 2;
   logic [RAD_W-1:0]          radius_shadow [DEPTH];

   always #5 clock = ~clock;

   tabulated_potential_interpolator_top i_dut (.*);

   tpi_checker i_checker (.*);

   // receiver: rotating stall patterns, with one long hold-off once hold_go is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt == 500) hold_done <= 1'b1;
      end else begin
         rx_cycle <= rx_cycle + 1;
         case ((rx_cycle / 97) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(1, 0));
            default: rsp_ready <= ($urandom_range(4, 0) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_request(input op_type op, input logic [IDX_W-1:0] idx,
                               input logic [RAD_W-1:0] rad, input logic [ENG_W-1:0] eng,
                               input logic [DSQ_W-1:0] dsq);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_entry_index <= idx;
      req_entry_radius <= rad;
      req_entry_energy <= eng;
      req_distance_squared <= dsq;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [RAD_W-1:0] rad,
                             input logic [ENG_W-1:0] eng);
      radius_shadow[idx] = rad;
      send_request(OP_LOAD, idx, rad, eng, $urandom);
   endtask

   task automatic query(input logic [DSQ_W-1:0] dsq);
      send_request(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, dsq);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [LEN_W-1:0] len, input logic [RAD_W-1:0] org,
                            input logic [RAD_W-1:0] sp, input logic [OVL_W-1:0] ovl);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_LENGTH;
      csr_write_data <= CSR_W'(len);
      @(posedge clock);
      csr_index <= CSR_ORIGIN;
      csr_write_data <= CSR_W'(org);
      @(posedge clock);
      csr_index <= CSR_SPACING;
      csr_write_data <= CSR_W'(sp);
      @(posedge clock);
      csr_index <= CSR_OVERLAP;
      csr_write_data <= ovl;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      eff_len = (len < 2) ? 2 : (len > DEPTH) ? DEPTH : len;
      @(posedge clock);
   endtask

   function automatic logic [DSQ_W-1:0] dsq_for(input bit [63:0] r);
      bit [63:0] sq;
      sq = (r * r) >> 16;
      return (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
   endfunction

   initial begin
      bit [63:0] lo;
      bit [63:0] hi;
      bit [63:0] org;
      bit [63:0] sp;
      int unsigned len;
      int nq;
      int kind;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: two entries, unit grid
      load_entry(0, 32'h0001_0000, 32'h8000_0000);
      load_entry(1, 32'h0003_0000, 32'h7FFF_FFFF);
      query(32'h0000_0000);
      query(32'h0001_0000);
      query(32'h0004_0000);
      query(32'h0009_0000);
      query(32'h0009_0001);
      query(32'hFFFF_FFFF);
      load_entry(10'h3FF, 32'hFFFF_FFFF, 32'h1234_5678);
      load_entry(1, 32'h0001_0000, 32'h0000_0100);
      query(32'h0001_0000);
      load_entry(1, 32'h0000_0000, 32'hFFFF_0000);
      query(32'h0000_8000);
      drain();

      // distance below origin and zero spacing, length below minimum
      configure(11'd0, 32'hFFFF_FFFF, 32'd0, 47'h7FFF_FFFF_FFFF);
      load_entry(0, 32'h0000_0000, 32'h0000_0005);
      load_entry(1, 32'h0004_0000, 32'hFFFF_FFF9);
      query(32'h0001_0000);
      query(32'h0000_0000);
      query(32'h0000_FFFF);
      query(32'h0010_0001);
      drain();
      configure(11'd2, 32'd0, 32'd0, 47'd0);
      query(32'h0002_0000);
      query(32'h0000_0001);
      drain();

      hold_go <= 1'b1;
      for (int ph = 0; ph < 16; ph++) begin
         case (ph)
            5: len = 2047;
            9: len = 1024;
            default: len = $urandom_range(24, 2);
         endcase
         case ($urandom_range(5, 0))
            0: sp = 0;
            1: sp = 1;
            2: sp = 32'hFFFF_FFFF;
            3: sp = 32'h0001_0000;
            default: sp = $urandom_range(32'h0010_0000 / 24, 1);
         endcase
         org = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FFFF : $urandom_range(32'h0040_0000, 0);
         // long tables: origin above every root keeps the interval at zero
         if (len > 100) org = 32'hFFFF_FFFF;
         configure(len[LEN_W-1:0], org[31:0], sp[31:0],
                   OVL_W'((ph % 3 == 0) ? 47'h7FFF_FFFF_FFFF : (ph % 3 == 1) ? 47'd0 :
                          {$urandom, $urandom} & 47'h7FFF_FFFF_FFFF));
         kind = $urandom_range(3, 0);
         lo = $urandom_range(32'h0040_0000, 0);
         for (int j = 0; j < eff_len; j++) begin
            bit [63:0] rad;
            case (kind)
               0: rad = $urandom;
               1: rad = lo + ((j / 2) * $urandom_range(32'h0008_0000, 0));
               default: rad = lo + j * ((sp == 0 || sp > 32'h0010_0000) ? 32'h0000_8000 : sp);
            endcase
            if (eff_len <= 100 || j < 2 || j == eff_len - 1)
               load_entry(j[IDX_W-1:0], rad[31:0], $urandom);
         end
         nq = (eff_len > 100) ? 30 : $urandom_range(50, 25);
         for (int k = 0; k < nq; k++) begin
            lo = radius_shadow[0];
            hi = radius_shadow[eff_len-1];
            case ($urandom_range(9, 0))
               0: query($urandom);
               1: load_entry(IDX_W'($urandom_range(eff_len - 1, 0)), $urandom, $urandom);
               2: load_entry(IDX_W'($urandom_range(DEPTH - 1, eff_len)), $urandom, $urandom);
               default: begin
                  if (hi >= lo) query(dsq_for(lo + {$urandom, $urandom} % (hi - lo + 1)));
                  else query(dsq_for($urandom_range(32'h0100_0000, 0)));
               end
            endcase
         end
         drain();
      end

      drain();
      repeat (150) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
